[rtl/sql_byte_stream_tokenizer_assert.svh]
// assertion macros for the sql tokenizer
`ifndef SQL_BYTE_STREAM_TOKENIZER_ASSERT_SVH
`define SQL_BYTE_STREAM_TOKENIZER_ASSERT_SVH
// property that must hold outside reset
`define SQLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the next edge
`define SQLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/sqlt_pkg.sv]
// shared types, codes and keyword lookup for the sql tokenizer
package sqlt_pkg;
    localparam int LINE_BITS_DEF = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [9:0] {
        M_IDLE  = 10'b0000000001,
        M_IDENT = 10'b0000000010,
        M_INT   = 10'b0000000100,
        M_FLOAT = 10'b0000001000,
        M_STR   = 10'b0000010000,
        M_ESC   = 10'b0000100000,
        M_BANG  = 10'b0001000000,
        M_LT    = 10'b0010000000,
        M_GT    = 10'b0100000000,
        M_MINUS = 10'b1000000000
    } t_mode;

    localparam logic [5:0] TK_END = 6'd0;
    localparam logic [5:0] TK_IDENT = 6'd1;
    localparam logic [5:0] TK_INT = 6'd2;
    localparam logic [5:0] TK_FLOAT = 6'd3;
    localparam logic [5:0] TK_STRING = 6'd4;
    localparam logic [5:0] TK_STAR = 6'd5;
    localparam logic [5:0] TK_COMMA = 6'd6;
    localparam logic [5:0] TK_LPAREN = 6'd7;
    localparam logic [5:0] TK_RPAREN = 6'd8;
    localparam logic [5:0] TK_SEMI = 6'd9;
    localparam logic [5:0] TK_DOT = 6'd10;
    localparam logic [5:0] TK_EQ = 6'd11;
    localparam logic [5:0] TK_NE = 6'd12;
    localparam logic [5:0] TK_LT = 6'd13;
    localparam logic [5:0] TK_LE = 6'd14;
    localparam logic [5:0] TK_GT = 6'd15;
    localparam logic [5:0] TK_GE = 6'd16;
    localparam logic [5:0] TK_SELECT = 6'd17;
    localparam logic [5:0] TK_FROM = 6'd18;
    localparam logic [5:0] TK_WHERE = 6'd19;
    localparam logic [5:0] TK_INSERT = 6'd20;
    localparam logic [5:0] TK_INTO = 6'd21;
    localparam logic [5:0] TK_VALUES = 6'd22;
    localparam logic [5:0] TK_DELETE = 6'd23;
    localparam logic [5:0] TK_CREATE = 6'd24;
    localparam logic [5:0] TK_TABLE = 6'd25;
    localparam logic [5:0] TK_JOIN = 6'd26;
    localparam logic [5:0] TK_ON = 6'd27;
    localparam logic [5:0] TK_AND = 6'd28;
    localparam logic [5:0] TK_OR = 6'd29;
    localparam logic [5:0] TK_NOT = 6'd30;
    localparam logic [5:0] TK_PRIMARY = 6'd31;
    localparam logic [5:0] TK_KEY = 6'd32;
    localparam logic [5:0] TK_INTEGER = 6'd33;
    localparam logic [5:0] TK_DOUBLE = 6'd34;
    localparam logic [5:0] TK_VARCHAR = 6'd35;
    localparam logic [5:0] TK_BOOLEAN = 6'd36;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // one result entry
    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [5:0]  tok;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } t_rec;

    // up to four results of one input beat, handed from front to back
    typedef struct packed {
        logic [2:0]   count;
        t_rec [3:0]   recs;
    } t_bundle;

    function automatic logic [5:0] kw_kind(input logic [55:0] b, input logic [3:0] n);
        logic [5:0] k;
        k = TK_IDENT;
        case (n)
            4'd2: case (b[55:40])
                "ON": k = TK_ON;
                "OR": k = TK_OR;
                default: k = TK_IDENT;
            endcase
            4'd3: case (b[55:32])
                "AND": k = TK_AND;
                "NOT": k = TK_NOT;
                "KEY": k = TK_KEY;
                "INT": k = TK_INTEGER;
                default: k = TK_IDENT;
            endcase
            4'd4: case (b[55:24])
                "FROM": k = TK_FROM;
                "INTO": k = TK_INTO;
                "JOIN": k = TK_JOIN;
                "BOOL": k = TK_BOOLEAN;
                default: k = TK_IDENT;
            endcase
            4'd5: case (b[55:16])
                "WHERE": k = TK_WHERE;
                "TABLE": k = TK_TABLE;
                "FLOAT": k = TK_DOUBLE;
                default: k = TK_IDENT;
            endcase
            4'd6: case (b[55:8])
                "SELECT": k = TK_SELECT;
                "INSERT": k = TK_INSERT;
                "VALUES": k = TK_VALUES;
                "DELETE": k = TK_DELETE;
                "CREATE": k = TK_CREATE;
                "DOUBLE": k = TK_DOUBLE;
                default: k = TK_IDENT;
            endcase
            4'd7: case (b)
                "PRIMARY": k = TK_PRIMARY;
                "INTEGER": k = TK_INTEGER;
                "VARCHAR": k = TK_VARCHAR;
                "BOOLEAN": k = TK_BOOLEAN;
                default: k = TK_IDENT;
            endcase
            default: k = TK_IDENT;
        endcase
        return k;
    endfunction
endpackage

[rtl/sql_byte_stream_tokenizer.sv]
// sql tokenizer top level: scanner front, result queue back
// Usage:
//   Input channel: push a beat with i_action/i_source_byte while full is low.
//   Each byte or end-of-input beat causes zero to four result beats: value
//   bytes of the token, then a token end record with kind, line and start
//   column. o_last marks the final beat caused by one input beat.
//   Result channel: the oldest beat sits on the o_ ports while empty is low
//   and leaves at a clock edge with pop high.
//   A result reaches the o_ ports through the registered head beat.
//   Throughput: one input beat per cycle while the queue has room; results
//   leave at one beat per cycle while pop is high, so input beats that cause
//   several results slow the input once the queue backs up.
//   An eight-beat queue feeds a registered head beat; full rises when the
//   queue holds more than four beats and so cannot take a four-beat bundle.
//   A stalled receiver thus stops the input after a few beats without loss.
//   Reset (synchronous, active low) empties the queue and returns the
//   scanner to line 1, column 1, between tokens; end of input resets the scanner so too.
module sql_byte_stream_tokenizer
    import sqlt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [7:0]  i_source_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_record_kind,
    output logic [7:0]  o_value_byte,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic        o_last
);
`include "sql_byte_stream_tokenizer_assert.svh"
    t_bundle bundle;
    t_rec rec;
    logic room;
    logic take;

    assign full = !room;
    assign take = push && room;

    sqlt_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(take),
        .i_action(i_action), .i_source_byte(i_source_byte), .o_bundle(bundle)
    );

    sqlt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bundle(bundle), .i_pop(pop),
        .o_room(room), .o_empty(empty), .o_rec(rec)
    );

    assign o_record_kind = rec.kind;
    assign o_value_byte = rec.value;
    assign o_token_kind = rec.tok;
    assign o_line_number = rec.line;
    assign o_column_number = rec.col;
    assign o_last = rec.last;

    `SQLT_ASSERT(a_bundle_size, i_clk, i_rst_n, bundle.count <= 3'd4, "bundle over four beats")
    `SQLT_ASSERT_NEXT(a_eoi_output, i_clk, i_rst_n, take && i_action, !empty, "end of input gave no beat")
    `SQLT_ASSERT(a_end_last, i_clk, i_rst_n, !(bundle.count != 3'd0 && !bundle.recs[2'(bundle.count - 3'd1)].last), "bundle tail not last")
endmodule

[rtl/sqlt_front.sv]
// scanner: classifies each byte and builds the results it causes
module sqlt_front
    import sqlt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_action,
    input  logic [7:0] i_source_byte,
    output t_bundle    o_bundle
);
    localparam logic [LINE_BITS-1:0] LMAX = '1;
    localparam logic [COLUMN_BITS-1:0] CMAX = '1;

    t_mode r_mode, n_mode;
    logic [7:0] r_kw [7];
    logic [3:0] r_len, n_len;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_start, n_start;
    logic kw_we;
    logic [2:0] kw_idx;
    logic [7:0] kw_data;
    logic [55:0] kw_flat;

    always_comb begin
        for (int i = 0; i < 7; i++) kw_flat[55-8*i -: 8] = r_kw[i];
    end

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_alp(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    always_comb begin
        t_bundle b;
        logic [7:0] c;
        logic rescan;
        logic [COLUMN_BITS-1:0] col_inc;
        logic [COLUMN_BITS-1:0] ts;
        logic [5:0] single;
        b = '0;
        c = i_source_byte;
        n_mode = r_mode;
        n_len = r_len;
        n_line = r_line;
        n_col = r_col;
        n_start = r_start;
        kw_we = 1'b0;
        kw_idx = r_len[2:0];
        kw_data = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        rescan = 1'b0;
        col_inc = (r_col < CMAX) ? r_col + 1'b1 : r_col;
        ts = r_start;
        single = TK_END;
        if (i_action) begin
            unique case (r_mode)
                M_IDENT: begin
                    b.recs[b.count[1:0]] = '{1'b1, 8'd0, kw_kind(kw_flat, r_len),
                        16'(r_line), 16'(r_start), 1'b0};
                    b.count++;
                end
                M_INT, M_FLOAT: begin
                    b.recs[b.count[1:0]] = '{1'b1, 8'd0,
                        (r_mode == M_INT) ? TK_INT : TK_FLOAT,
                        16'(r_line), 16'(r_start), 1'b0};
                    b.count++;
                end
                M_STR, M_ESC: begin
                    b.recs[b.count[1:0]] = '{1'b1, 8'd0, TK_STRING, 16'(r_line),
                        16'(r_start), 1'b0};
                    b.count++;
                end
                M_LT, M_GT: begin
                    b.recs[b.count[1:0]] = '{1'b0, (r_mode == M_LT) ? "<" : ">", TK_END,
                        16'd0, 16'd0, 1'b0};
                    b.count++;
                    b.recs[b.count[1:0]] = '{1'b1, 8'd0, (r_mode == M_LT) ? TK_LT : TK_GT,
                        16'(r_line), 16'(r_start), 1'b0};
                    b.count++;
                end
                default: ;
            endcase
            b.recs[b.count[1:0]] = '{1'b1, 8'd0, TK_END, 16'(r_line), 16'(r_col), 1'b0};
            b.count++;
            n_mode = M_IDLE;
            n_len = '0;
            n_line = LINE_BITS'(1);
            n_col = COLUMN_BITS'(1);
            n_start = '0;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_alp(c) || is_dig(c) || c == CH_UNDER) begin
                        kw_we = r_len < 4'd7;
                        n_len = (r_len < 4'd7) ? r_len + 4'd1 : 4'd8;
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        n_col = col_inc;
                    end else begin
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, kw_kind(kw_flat, r_len),
                            16'(r_line), 16'(r_start), 1'b0};
                        b.count++;
                        rescan = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_dig(c) || c == ".") begin
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        if (c == ".") n_mode = M_FLOAT;
                        n_col = col_inc;
                    end else begin
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, TK_INT, 16'(r_line),
                            16'(r_start), 1'b0};
                        b.count++;
                        rescan = 1'b1;
                    end
                end
                M_FLOAT: begin
                    if (is_dig(c)) begin
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        n_col = col_inc;
                    end else begin
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, TK_FLOAT, 16'(r_line),
                            16'(r_start), 1'b0};
                        b.count++;
                        rescan = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, TK_STRING, 16'(r_line),
                            16'(r_start), 1'b0};
                        b.count++;
                        n_mode = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                    end
                    n_col = col_inc;
                end
                M_ESC: begin
                    b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                    b.count++;
                    n_mode = M_STR;
                    n_col = col_inc;
                end
                M_BANG, M_LT, M_GT: begin
                    if (c == "=") begin
                        b.recs[b.count[1:0]] = '{1'b0, (r_mode == M_BANG) ? "!" :
                            ((r_mode == M_LT) ? "<" : ">"), TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, (r_mode == M_BANG) ? TK_NE :
                            ((r_mode == M_LT) ? TK_LE : TK_GE), 16'(r_line),
                            16'(r_start), 1'b0};
                        b.count++;
                        n_mode = M_IDLE;
                        n_col = col_inc;
                    end else begin
                        if (r_mode != M_BANG) begin
                            b.recs[b.count[1:0]] = '{1'b0, (r_mode == M_LT) ? "<" : ">",
                                TK_END, 16'd0, 16'd0, 1'b0};
                            b.count++;
                            b.recs[b.count[1:0]] = '{1'b1, 8'd0, (r_mode == M_LT) ? TK_LT :
                                TK_GT, 16'(r_line), 16'(r_start), 1'b0};
                            b.count++;
                        end
                        rescan = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (is_dig(c)) begin
                        b.recs[b.count[1:0]] = '{1'b0, "-", TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        n_mode = M_INT;
                        n_col = col_inc;
                    end else begin
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            // byte scanned afresh between tokens: whitespace is skipped, else a new token may start
            if (rescan) begin
                n_mode = M_IDLE;
                if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
                    if (c == 8'h0A) begin
                        n_line = (r_line < LMAX) ? r_line + 1'b1 : r_line;
                        n_col = COLUMN_BITS'(1);
                    end else begin
                        n_col = col_inc;
                    end
                end else begin
                    n_start = r_col;
                    ts = r_col;
                    n_col = col_inc;
                    case (c)
                        "*": single = TK_STAR;
                        ",": single = TK_COMMA;
                        "(": single = TK_LPAREN;
                        ")": single = TK_RPAREN;
                        ";": single = TK_SEMI;
                        ".": single = TK_DOT;
                        "=": single = TK_EQ;
                        "!": n_mode = M_BANG;
                        "<": n_mode = M_LT;
                        ">": n_mode = M_GT;
                        "-": n_mode = M_MINUS;
                        CH_QUOTE: n_mode = M_STR;
                        default: begin
                            if (is_dig(c)) begin
                                b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0,
                                    1'b0};
                                b.count++;
                                n_mode = M_INT;
                            end else if (is_alp(c) || c == CH_UNDER) begin
                                kw_we = 1'b1;
                                kw_idx = 3'd0;
                                n_len = 4'd1;
                                b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0,
                                    1'b0};
                                b.count++;
                                n_mode = M_IDENT;
                            end
                        end
                    endcase
                    if (single != TK_END) begin
                        b.recs[b.count[1:0]] = '{1'b0, c, TK_END, 16'd0, 16'd0, 1'b0};
                        b.count++;
                        b.recs[b.count[1:0]] = '{1'b1, 8'd0, single, 16'(r_line),
                            16'(ts), 1'b0};
                        b.count++;
                    end
                end
            end
        end
        if (b.count != 3'd0) b.recs[2'(b.count - 3'd1)].last = 1'b1;
        if (!i_valid) b.count = 3'd0;
        o_bundle = b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len <= '0;
            r_line <= LINE_BITS'(1);
            r_col <= COLUMN_BITS'(1);
            r_start <= '0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_len <= n_len;
            r_line <= n_line;
            r_col <= n_col;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !i_action && kw_we) r_kw[kw_idx] <= kw_data;
    end
endmodule

[rtl/sqlt_back.sv]
// result queue: takes a bundle of beats and drains one beat per pop
module sqlt_back
    import sqlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_empty,
    output t_rec    o_rec
);
    localparam int DEPTH = 2 * QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);

    t_rec r_mem [DEPTH];
    t_rec r_head;
    logic r_head_vld;
    logic [AW-1:0] r_rd, r_wr;
    logic [AW:0] r_cnt;
    logic pop_ok;
    logic load;
    logic from_mem;
    logic from_bun;
    logic [2:0] skip;

    assign o_empty = !r_head_vld;
    assign pop_ok = i_pop && r_head_vld;
    assign o_rec = r_head;
    assign load = !r_head_vld || pop_ok;
    assign from_mem = load && (r_cnt != '0);
    // with the queue empty and the head free or popped, the first beat of a bundle goes straight to the head
    assign from_bun = load && (r_cnt == '0) && (i_bundle.count != 3'd0);
    assign skip = from_bun ? 3'd1 : 3'd0;
    // room for a full bundle of four beats
    assign o_room = (r_cnt <= (AW+1)'(DEPTH - QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (3'(i) >= skip && 3'(i) < i_bundle.count)
                r_mem[r_wr + AW'(3'(i) - skip)] <= i_bundle.recs[i];
        end
        if (from_mem) r_head <= r_mem[r_rd];
        else if (from_bun) r_head <= i_bundle.recs[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_cnt <= '0;
            r_head_vld <= 1'b0;
        end else begin
            r_wr <= r_wr + AW'(i_bundle.count - skip);
            if (from_mem) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_bundle.count - skip) - (AW+1)'(from_mem);
            if (load) r_head_vld <= from_mem || from_bun;
        end
    end
endmodule
